/* rtl/xtea_pkg.sv */
// shared types, constants and the round-sum helper for the xtea block cipher
// no dependencies; used by every module in rtl/
`default_nettype none

package xtea_pkg;

   localparam int unsigned WORD_WIDTH = 32;
   localparam int unsigned KEY_WORDS = 4;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned DEFAULT_ROUND_COUNT = 32;
   localparam logic [WORD_WIDTH-1:0] DELTA = 32'h9e37_79b9;

   // register indexes of the configuration port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_KEY_ZERO  = 3'd0,
      CSR_KEY_ONE   = 3'd1,
      CSR_KEY_TWO   = 3'd2,
      CSR_KEY_THREE = 3'd3
   } csr_index_type;

   typedef logic [KEY_WORDS-1:0][WORD_WIDTH-1:0] key_type;

   // one block on its way through the pipeline
   typedef struct packed {
      logic [WORD_WIDTH-1:0] low;
      logic [WORD_WIDTH-1:0] high;
      logic                  direction;
   } block_type;

   // delta times a round number, modulo 2^32
   function automatic logic [WORD_WIDTH-1:0] delta_times(input int unsigned count);
      logic [2*WORD_WIDTH-1:0] product;
      product = (2*WORD_WIDTH)'(DELTA) * (2*WORD_WIDTH)'(count);
      return product[WORD_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/xtea_key_regs.sv */
// 128-bit key register file written through the configuration port
// depends on xtea_pkg
`default_nettype none

module xtea_key_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [xtea_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [xtea_pkg::WORD_WIDTH-1:0]      csr_write_data,
   output xtea_pkg::key_type                         key
);

   xtea_pkg::key_type key_ff;
   xtea_pkg::key_type key_in;

   always_comb begin
      key_in = key_ff;
      if (csr_write_enable) begin
         unique case (xtea_pkg::csr_index_type'(csr_index))
            xtea_pkg::CSR_KEY_ZERO:  key_in[0] = csr_write_data;
            xtea_pkg::CSR_KEY_ONE:   key_in[1] = csr_write_data;
            xtea_pkg::CSR_KEY_TWO:   key_in[2] = csr_write_data;
            xtea_pkg::CSR_KEY_THREE: key_in[3] = csr_write_data;
            default:                 key_in = key_ff; // unused index, ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   assign key = key_ff;

endmodule

`default_nettype wire

/* rtl/xtea_half_round.sv */
// one registered feistel half-round with valid/stall flow control
// depends on xtea_pkg
`default_nettype none

module xtea_half_round #(
   parameter logic [xtea_pkg::WORD_WIDTH-1:0] ENC_SUM = '0,
   parameter logic [xtea_pkg::WORD_WIDTH-1:0] DEC_SUM = '0,
   parameter bit                              FIRST_HALF = 1'b1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire xtea_pkg::key_type key,
   input  wire logic          up_valid,
   input  wire xtea_pkg::block_type up_block,
   output logic               up_stall,
   output logic               dn_valid,
   output xtea_pkg::block_type dn_block,
   input  wire logic          dn_stall
);

   logic                  valid_ff;
   logic                  valid_in;
   xtea_pkg::block_type   block_ff;
   xtea_pkg::block_type   block_in;
   logic                  load;
   logic                  update_low;
   logic [xtea_pkg::WORD_WIDTH-1:0] sum;
   logic [1:0]            key_sel;
   logic [xtea_pkg::WORD_WIDTH-1:0] src;
   logic [xtea_pkg::WORD_WIDTH-1:0] dst;
   logic [xtea_pkg::WORD_WIDTH-1:0] mix;
   logic [xtea_pkg::WORD_WIDTH-1:0] result;

   // stage holds while it is full and the next one stalls
   assign up_stall = valid_ff & dn_stall;
   assign load     = ~up_stall;

   always_comb begin
      // encipher updates low on the first half, decipher on the second
      update_low = (up_block.direction == 1'b0) == FIRST_HALF;
      sum        = up_block.direction ? DEC_SUM : ENC_SUM;
      key_sel    = update_low ? sum[1:0] : sum[12:11];
      src        = update_low ? up_block.high : up_block.low;
      dst        = update_low ? up_block.low : up_block.high;
      mix        = (((src << 4) ^ (src >> 5)) + src) ^ (sum + key[key_sel]);
      result     = up_block.direction ? (dst - mix) : (dst + mix);

      block_in = up_block;
      if (update_low) begin
         block_in.low = result;
      end else begin
         block_in.high = result;
      end
      valid_in = load ? up_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && up_valid) begin
         block_ff <= block_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_block = block_ff;

endmodule

`default_nettype wire

/* rtl/xtea_block_cipher.sv */
// top level of the pipelined xtea block cipher
// depends on xtea_pkg, xtea_key_regs and xtea_half_round
`default_nettype none

// usage
//   request channel: req_valid with req_block_low, req_block_high and
//   req_direction (0 encipher, 1 decipher); taken at a clock edge with
//   req_valid high and req_stall low
//   response channel: rsp_valid with rsp_out_low and rsp_out_high; taken at
//   an edge with rsp_valid high and rsp_stall low, one response per request
//   in request order
//   configuration: csr_write_enable, csr_index (0..3 select the key words,
//   other indexes are ignored) and csr_write_data; write the key only while
//   no request is in flight
// pipeline and throughput
//   a fully unrolled pipeline of 2*ROUND_COUNT half-round stages, one
//   register each; a taken request passes through the stages in order and
//   leaves from the last stage register onto the response port
//   one request per clock is taken when the response side keeps up
// reset
//   synchronous, active high: empties the pipeline and clears the key to 0
// stall
//   a stalled response holds in the last stage; each stage takes new data
//   while it is empty or its successor moves, so bubbles close up and
//   requests keep entering until the pipeline is full

module xtea_block_cipher #(
   parameter int unsigned ROUND_COUNT = xtea_pkg::DEFAULT_ROUND_COUNT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_write_enable,
   input  wire logic [xtea_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [xtea_pkg::WORD_WIDTH-1:0]      csr_write_data,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [xtea_pkg::WORD_WIDTH-1:0]      req_block_low,
   input  wire logic [xtea_pkg::WORD_WIDTH-1:0]      req_block_high,
   input  wire logic                                 req_direction,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [xtea_pkg::WORD_WIDTH-1:0]           rsp_out_low,
   output logic [xtea_pkg::WORD_WIDTH-1:0]           rsp_out_high
);

   // two half-rounds per cipher round
   localparam int unsigned STAGES = 2 * ROUND_COUNT;

   xtea_pkg::key_type   key;
   logic                valid [0:STAGES];
   logic                stall [0:STAGES];
   xtea_pkg::block_type block [0:STAGES];

   xtea_key_regs u_key_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .key              (key)
   );

   // pipeline entry
   assign valid[0]           = req_valid;
   assign block[0].low       = req_block_low;
   assign block[0].high      = req_block_high;
   assign block[0].direction = req_direction;
   assign req_stall          = stall[0];

   genvar j;
   generate
      for (j = 0; j < STAGES; j++) begin : g_stage
         // round sums are fixed per stage: encipher counts up from 0,
         // decipher counts down from delta times the round count
         localparam int unsigned ENC_COUNT = j / 2 + j % 2;
         localparam int unsigned DEC_COUNT = ROUND_COUNT - j / 2 - j % 2;

         xtea_half_round #(
            .ENC_SUM    (xtea_pkg::delta_times(ENC_COUNT)),
            .DEC_SUM    (xtea_pkg::delta_times(DEC_COUNT)),
            .FIRST_HALF ((j % 2) == 0)
         ) u_half_round (
            .clock    (clock),
            .reset    (reset),
            .key      (key),
            .up_valid (valid[j]),
            .up_block (block[j]),
            .up_stall (stall[j]),
            .dn_valid (valid[j+1]),
            .dn_block (block[j+1]),
            .dn_stall (stall[j+1])
         );
      end
   endgenerate

   // last stage register doubles as the response register
   assign stall[STAGES] = rsp_stall;
   assign rsp_valid     = valid[STAGES];
   assign rsp_out_low   = block[STAGES].low;
   assign rsp_out_high  = block[STAGES].high;

endmodule

`default_nettype wire

/* bench/xtea_block_cipher_tb.sv */
// self-checking testbench for the pipelined xtea block cipher
// needs xtea_pkg and xtea_block_cipher from rtl/; predicts every response in its own xtea model
`timescale 1ns / 1ps

module xtea_block_cipher_tb;

   localparam int unsigned ROUND_COUNT = xtea_pkg::DEFAULT_ROUND_COUNT;
   localparam int unsigned PIPE_DEPTH = 2 * ROUND_COUNT;
   localparam int unsigned DRAIN_LIMIT = 50000;

   // expected contents of one response
   typedef struct packed {
      logic [xtea_pkg::WORD_WIDTH-1:0] low;
      logic [xtea_pkg::WORD_WIDTH-1:0] high;
   } cipher_block_type;

   // receiver behavior, changed from phase to phase
   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_BURSTY
   } stall_style_type;

   localparam logic DIR_ENCIPHER = 1'b0;
   localparam logic DIR_DECIPHER = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 csr_write_enable = 1'b0;
   logic [xtea_pkg::CSR_INDEX_WIDTH-1:0] csr_index = xtea_pkg::CSR_KEY_ZERO;
   logic [xtea_pkg::WORD_WIDTH-1:0]      csr_write_data = '0;

   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [xtea_pkg::WORD_WIDTH-1:0] req_block_low = '0;
   logic [xtea_pkg::WORD_WIDTH-1:0] req_block_high = '0;
   logic                            req_direction = DIR_ENCIPHER;

   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [xtea_pkg::WORD_WIDTH-1:0] rsp_out_low;
   logic [xtea_pkg::WORD_WIDTH-1:0] rsp_out_high;

   // key as the block should hold it after the writes seen so far
   xtea_pkg::key_type key_shadow = '0;

   // responses predicted for accepted requests, oldest first
   cipher_block_type pending_blocks[$];

   int unsigned     mismatch_count = 0;
   stall_style_type stall_style = STALL_NONE;
   logic            sender_gaps = 1'b1;
   int unsigned     burst_left = 1;
   logic [4:0]      stall_phase = '0;

   xtea_block_cipher #(
      .ROUND_COUNT(ROUND_COUNT)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_block_low   (req_block_low),
      .req_block_high  (req_block_high),
      .req_direction   (req_direction),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_low     (rsp_out_low),
      .rsp_out_high    (rsp_out_high)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // hard stop in case the pipeline hangs
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // one feistel half-round mixing term, all modulo 2^32
   function automatic logic [xtea_pkg::WORD_WIDTH-1:0] feistel_mix(
         input logic [xtea_pkg::WORD_WIDTH-1:0] v,
         input logic [xtea_pkg::WORD_WIDTH-1:0] sum,
         input logic [xtea_pkg::WORD_WIDTH-1:0] k);
      return (((v << 4) ^ (v >> 5)) + v) ^ (sum + k);
   endfunction

   // full xtea transform of one block under the shadow key
   function automatic cipher_block_type xtea_transform(
         input logic [xtea_pkg::WORD_WIDTH-1:0] low,
         input logic [xtea_pkg::WORD_WIDTH-1:0] high,
         input logic direction);
      logic [xtea_pkg::WORD_WIDTH-1:0] v0;
      logic [xtea_pkg::WORD_WIDTH-1:0] v1;
      logic [xtea_pkg::WORD_WIDTH-1:0] sum;
      v0 = low;
      v1 = high;
      sum = '0;
      if (direction == DIR_ENCIPHER) begin
         for (int i = 0; i < ROUND_COUNT; i++) begin
            v0 += feistel_mix(v1, sum, key_shadow[sum[1:0]]);
            sum += xtea_pkg::DELTA;
            v1 += feistel_mix(v0, sum, key_shadow[sum[12:11]]);
         end
      end else begin
         // decipher starts from the sum that enciphering ends on
         repeat (ROUND_COUNT) sum += xtea_pkg::DELTA;
         for (int i = 0; i < ROUND_COUNT; i++) begin
            v1 -= feistel_mix(v0, sum, key_shadow[sum[12:11]]);
            sum -= xtea_pkg::DELTA;
            v0 -= feistel_mix(v1, sum, key_shadow[sum[1:0]]);
         end
      end
      return '{low: v0, high: v1};
   endfunction

   // mostly random words, with the extremes mixed in now and then
   function automatic logic [xtea_pkg::WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return 32'h8000_0000;
         3: return 32'h7fff_ffff;
         default: return $urandom();
      endcase
   endfunction

   // receiver stall pattern, independent of the sender
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1'b1;
      case (stall_style)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_LIGHT:  rsp_stall <= ($urandom_range(0, 99) < 25);
         STALL_HEAVY:  rsp_stall <= ($urandom_range(0, 99) < 75);
         STALL_BURSTY: rsp_stall <= (stall_phase[4:3] == 2'b11) || ($urandom_range(0, 9) == 0);
         default:      rsp_stall <= 1'b0;
      endcase
   end

   // response checker: every accepted response against the oldest prediction
   always @(posedge clock) begin : check_responses
      cipher_block_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_blocks.size() == 0) begin
            $display("%0t: unexpected response, expected none, got low %h high %h",
                     $time, rsp_out_low, rsp_out_high);
            mismatch_count++;
         end else begin
            want = pending_blocks.pop_front();
            if (rsp_out_low !== want.low) begin
               $display("%0t: out_low mismatch, expected %h, got %h",
                        $time, want.low, rsp_out_low);
               mismatch_count++;
            end
            if (rsp_out_high !== want.high) begin
               $display("%0t: out_high mismatch, expected %h, got %h",
                        $time, want.high, rsp_out_high);
               mismatch_count++;
            end
         end
      end
   end

   // present one request, hold it until taken, then maybe open a gap
   task automatic send_block(input logic [xtea_pkg::WORD_WIDTH-1:0] low,
                             input logic [xtea_pkg::WORD_WIDTH-1:0] high,
                             input logic direction);
      req_valid <= 1'b1;
      req_block_low <= low;
      req_block_high <= high;
      req_direction <= direction;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_blocks.push_back(xtea_transform(low, high, direction));
      if (sender_gaps) begin
         if (burst_left <= 1) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            burst_left = $urandom_range(1, 16);
         end else begin
            burst_left--;
         end
      end
   endtask

   // let every request in flight come out before touching the key
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_blocks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // one register write; enable drops between writes
   task automatic write_register(input logic [xtea_pkg::CSR_INDEX_WIDTH-1:0] index,
                                 input logic [xtea_pkg::WORD_WIDTH-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      // indexes past the last key word are ignored by the block
      if (index <= xtea_pkg::CSR_KEY_THREE) key_shadow[index[1:0]] = data;
   endtask

   task automatic load_key(input xtea_pkg::key_type key);
      write_register(xtea_pkg::CSR_KEY_ZERO, key[0]);
      write_register(xtea_pkg::CSR_KEY_ONE, key[1]);
      write_register(xtea_pkg::CSR_KEY_TWO, key[2]);
      write_register(xtea_pkg::CSR_KEY_THREE, key[3]);
   endtask

   // key is all zero out of reset; block extremes in both directions
   task automatic test_reset_key();
      stall_style = STALL_NONE;
      sender_gaps = 1'b0;
      send_block('0, '0, DIR_ENCIPHER);
      send_block('0, '0, DIR_DECIPHER);
      send_block('1, '1, DIR_ENCIPHER);
      send_block('1, '1, DIR_DECIPHER);
      send_block(32'haaaa_aaaa, 32'h5555_5555, DIR_ENCIPHER);
      send_block(32'h5555_5555, 32'haaaa_aaaa, DIR_DECIPHER);
      send_block(32'h8000_0000, 32'h0000_0001, DIR_ENCIPHER);
      send_block(32'h7fff_ffff, 32'hffff_fffe, DIR_DECIPHER);
      wait_idle();
   endtask

   // all-ones key and a mixed key, with both block extremes
   task automatic test_key_extremes();
      xtea_pkg::key_type key;
      stall_style = STALL_LIGHT;
      sender_gaps = 1'b1;
      key = {32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff};
      load_key(key);
      send_block('0, '1, DIR_ENCIPHER);
      send_block('1, '0, DIR_DECIPHER);
      send_block('1, '1, DIR_ENCIPHER);
      send_block('0, '0, DIR_DECIPHER);
      wait_idle();
      key = {32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001};
      load_key(key);
      send_block('0, '0, DIR_ENCIPHER);
      send_block('1, '1, DIR_DECIPHER);
      send_block(32'h0123_4567, 32'h89ab_cdef, DIR_ENCIPHER);
      send_block(32'h89ab_cdef, 32'h0123_4567, DIR_DECIPHER);
      wait_idle();
   endtask

   // writes to indexes past the key words must leave the key alone
   task automatic test_ignored_indexes();
      for (int index = int'(xtea_pkg::CSR_KEY_THREE) + 1;
           index < (1 << xtea_pkg::CSR_INDEX_WIDTH); index++) begin
         write_register(index[xtea_pkg::CSR_INDEX_WIDTH-1:0], $urandom());
      end
      send_block($urandom(), $urandom(), DIR_ENCIPHER);
      send_block($urandom(), $urandom(), DIR_DECIPHER);
      wait_idle();
   endtask

   // decipher of a ciphertext should give the plain block back
   task automatic test_round_trip();
      xtea_pkg::key_type key;
      cipher_block_type plain;
      cipher_block_type coded;
      key = {$urandom(), $urandom(), $urandom(), $urandom()};
      load_key(key);
      stall_style = STALL_BURSTY;
      for (int i = 0; i < 3; i++) begin
         plain = '{low: $urandom(), high: $urandom()};
         coded = xtea_transform(plain.low, plain.high, DIR_ENCIPHER);
         send_block(plain.low, plain.high, DIR_ENCIPHER);
         send_block(coded.low, coded.high, DIR_DECIPHER);
      end
      wait_idle();
   endtask

   // bulk traffic over several keys, stall styles and sender patterns
   task automatic test_random_traffic();
      xtea_pkg::key_type key;
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 1) begin
            key = {32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000};
         end else begin
            key = {$urandom(), $urandom(), $urandom(), $urandom()};
         end
         load_key(key);
         stall_style = stall_style_type'(phase % 4);
         // last phase runs flat out on both sides
         sender_gaps = (phase != 4) && (phase != 2);
         if (phase == 4) stall_style = STALL_NONE;
         burst_left = $urandom_range(1, 16);
         for (int i = 0; i < 100; i++) begin
            send_block(pick_word(), pick_word(), 1'($urandom_range(0, 1)));
         end
         wait_idle();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_key();
      test_key_extremes();
      test_ignored_indexes();
      test_round_trip();
      test_random_traffic();

      // bounded drain, then watch for stray responses
      req_valid <= 1'b0;
      for (int n = 0; n < DRAIN_LIMIT && pending_blocks.size() != 0; n++) @(posedge clock);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      if (pending_blocks.size() != 0) begin
         $display("%0t: %0d responses never arrived, expected low %h high %h",
                  $time, pending_blocks.size(), pending_blocks[0].low, pending_blocks[0].high);
         mismatch_count++;
      end

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
